// ===== hdl/dbslf_pkg.sv =====
// ---------------------------------------------------------------------------
// dbslf_pkg
// Shared types, register indexes, fit constants and the round/saturate step
// of the depth bin sampler with line fit.
// ---------------------------------------------------------------------------
package dbslf_pkg;

    localparam int DEF_MAX_BINS   = 128;
    localparam int DEF_DEPTH_BITS = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DEPTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT = 2'd2;

    localparam logic [15:0] RST_MIN_DEPTH = 16'd0;
    localparam logic [15:0] RST_MAX_DEPTH = 16'd3500;
    localparam logic [7:0]  RST_BIN_COUNT = 8'd100;

    localparam int SLOPE_FRAC  = 16;
    localparam int OFFSET_FRAC = 8;

    // Quotient width kept by the divider; anything larger saturates anyway.
    localparam int Q_W   = 26;
    localparam int RES_W = 24;

    localparam logic [Q_W:0] SAT_POS = (Q_W+1)'((1 << (RES_W - 1)) - 1);
    localparam logic [Q_W:0] SAT_NEG = (Q_W+1)'(1 << (RES_W - 1));

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RANGE,
        ST_BIN_MUL,
        ST_BIN_DIV,
        ST_LOOKUP,
        ST_STORE,
        ST_SQ_MUL,
        ST_CROSS_MUL,
        ST_FIT,
        ST_DEN_MUL,
        ST_DEN_SQ,
        ST_SN_MUL,
        ST_SN_CROSS,
        ST_SLOPE_DIV,
        ST_ON_MUL,
        ST_ON_CROSS,
        ST_OFFSET_DIV,
        ST_OUT
    } t_state;

    // The quotient carries one extra fraction bit; round half away from zero,
    // then clamp the magnitude to the signed result range.
    function automatic logic [RES_W-1:0] round_sat(input logic [Q_W-1:0] q,
                                                   input logic ovf,
                                                   input logic neg);
        logic [Q_W:0] qr;
        logic [Q_W:0] mag;
        logic [Q_W:0] negm;
        qr = ({1'b0, q} + {{Q_W{1'b0}}, 1'b1}) >> 1;
        if (neg) begin
            mag  = (ovf || (qr > SAT_NEG)) ? SAT_NEG : qr;
            negm = ~mag + {{Q_W{1'b0}}, 1'b1};
            return negm[RES_W-1:0];
        end
        mag = (ovf || (qr > SAT_POS)) ? SAT_POS : qr;
        return mag[RES_W-1:0];
    endfunction

endpackage

// ===== hdl/dbslf_mul.sv =====
// ---------------------------------------------------------------------------
// dbslf_mul
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle, LSB
// first; finishes as soon as the remaining multiplier bits are all zero.
// ---------------------------------------------------------------------------
module dbslf_mul #(
    parameter int P_W = 62,
    parameter int B_W = 23
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [P_W-1:0] i_a,
    input  logic [B_W-1:0] i_b,
    output logic           o_done,
    output logic [P_W-1:0] o_prod
);
    logic           r_busy, n_busy;
    logic [P_W-1:0] r_a, n_a;
    logic [B_W-1:0] r_b, n_b;
    logic [P_W-1:0] r_acc, n_acc;

    assign o_done = r_busy && (r_b == '0);
    assign o_prod = r_acc;

    always_comb begin
        n_busy = r_busy;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        if (i_start) begin
            n_busy = 1'b1;
            n_a    = i_a;
            n_b    = i_b;
            n_acc  = '0;
        end else if (r_busy) begin
            if (r_b == '0) begin
                n_busy = 1'b0;
            end else begin
                if (r_b[0]) begin
                    n_acc = r_acc + r_a;
                end
                n_a = r_a << 1;
                n_b = r_b >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
    end
endmodule

// ===== hdl/dbslf_div.sv =====
// ---------------------------------------------------------------------------
// dbslf_div
// Restoring divider, one quotient bit per cycle. The numerator arrives
// left-aligned; zeros shift in after it for the fraction bits.
// ---------------------------------------------------------------------------
module dbslf_div #(
    parameter int P_W = 62,
    parameter int D_W = 47,
    parameter int S_W = 7
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [P_W-1:0] i_num,
    input  logic [S_W-1:0] i_steps,
    input  logic [D_W-1:0] i_den,
    output logic           o_done,
    output logic [dbslf_pkg::Q_W-1:0] o_quo,
    output logic           o_ovf
);
    import dbslf_pkg::*;

    logic           r_busy, n_busy;
    logic [P_W-1:0] r_num, n_num;
    logic [D_W-1:0] r_den, n_den;
    logic [D_W-1:0] r_rem, n_rem;
    logic [S_W-1:0] r_cnt, n_cnt;
    logic [Q_W-1:0] r_q, n_q;
    logic           r_ovf, n_ovf;
    logic [D_W:0]   w_rem_sh;
    logic [D_W:0]   w_diff;
    logic           w_ge;

    assign o_done = r_busy && (r_cnt == '0);
    assign o_quo  = r_q;
    assign o_ovf  = r_ovf;

    assign w_rem_sh = {r_rem, r_num[P_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_den};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});

    always_comb begin
        n_busy = r_busy;
        n_num  = r_num;
        n_den  = r_den;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_ovf  = r_ovf;
        if (i_start) begin
            n_busy = 1'b1;
            n_num  = i_num;
            n_den  = i_den;
            n_rem  = '0;
            n_cnt  = i_steps;
            n_q    = '0;
            n_ovf  = 1'b0;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end else begin
                n_num = r_num << 1;
                n_rem = w_ge ? w_diff[D_W-1:0] : w_rem_sh[D_W-1:0];
                n_ovf = r_ovf | r_q[Q_W-1];
                n_q   = {r_q[Q_W-2:0], w_ge};
                n_cnt = r_cnt - {{(S_W-1){1'b0}}, 1'b1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_num <= n_num;
        r_den <= n_den;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        r_q   <= n_q;
        r_ovf <= n_ovf;
    end
endmodule

// ===== hdl/depth_bin_sample_line_fit.sv =====
// ---------------------------------------------------------------------------
// depth_bin_sample_line_fit
// Bins target depths, keeps one sample pair per bin and refits
// target = slope * measured + offset by least squares after every item.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries a target and a measured depth.
//   Output channel (o_valid / i_stall) returns one result per input.
//   Configuration writes (i_cfg_valid / o_cfg_ready) set the depth window and
//   bin count; they are taken at any time and should be made while idle.
//   One item is worked at a time and the input stalls until it is done. An
//   out-of-range item with fewer than two samples stored passes only the
//   range and fit checks (ST_RANGE, ST_FIT) before ST_OUT loads its result; a
//   stored item with a full refit also waits on the shared bit-serial
//   multiplier (one bit per cycle, nine products at most) and the restoring
//   divider (one quotient bit per cycle: bin, slope and offset divisions).
//   A finished result sits in the output register; the next input is taken
//   while it waits, and a new result waits until that one is transferred.
//   Reset clears the count and sums and loads the window 0..3500 mm with 100
//   bins; a clearing pass over all MAX_BINS flags then empties the bin store.
// ---------------------------------------------------------------------------
module depth_bin_sample_line_fit #(
    parameter int MAX_BINS   = dbslf_pkg::DEF_MAX_BINS,
    parameter int DEPTH_BITS = dbslf_pkg::DEF_DEPTH_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dbslf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dbslf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [15:0]                    i_target_depth,
    input  logic [15:0]                    i_measured_depth,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_in_range,
    output logic [6:0]                     o_bin_num,
    output logic                           o_accepted,
    output logic [7:0]                     o_sample_count,
    output logic                           o_fit_valid,
    output logic signed [23:0]             o_slope,
    output logic signed [23:0]             o_offset
);
    import dbslf_pkg::*;

    localparam int BI_W  = $clog2(MAX_BINS);
    localparam int N_W   = $clog2(MAX_BINS + 1);
    localparam int SX_W  = DEPTH_BITS + BI_W;
    localparam int SXX_W = 2 * DEPTH_BITS + BI_W;
    localparam int P_W   = SXX_W + SX_W;
    localparam int D_W   = SXX_W + N_W;
    localparam int B_W   = SX_W;
    localparam int BN_W  = BI_W + DEPTH_BITS;
    localparam int SL_STEPS = D_W + SLOPE_FRAC + 1;
    localparam int OF_STEPS = P_W + OFFSET_FRAC + 1;
    localparam int STEP_MAX = (SL_STEPS > OF_STEPS) ? SL_STEPS : OF_STEPS;
    localparam int S_W   = $clog2(STEP_MAX + 1);

    t_state r_state, n_state;
    logic   r_wait, n_wait;

    logic [15:0] r_min, r_max;
    logic [7:0]  r_bins;

    logic [DEPTH_BITS-1:0] r_t, n_t, r_m, n_m;
    logic                  r_inr, n_inr, r_acc, n_acc;
    logic [BI_W-1:0]       r_bin, n_bin;
    logic                  r_taken_mem [MAX_BINS];
    logic                  r_taken_rd;
    logic [BI_W-1:0]       r_clr, n_clr;
    logic                  w_tk_we, w_tk_wdata;
    logic [BI_W-1:0]       w_tk_addr;
    logic [N_W-1:0]        r_n, n_n;
    logic [SX_W-1:0]       r_sx, n_sx, r_sy, n_sy;
    logic [SXX_W-1:0]      r_sxx, n_sxx, r_sxy, n_sxy;
    logic [P_W-1:0]        r_prod, n_prod;
    logic [D_W-1:0]        r_den, n_den;
    logic [P_W-1:0]        r_num, n_num;
    logic                  r_neg, n_neg;
    logic                  r_fitv, n_fitv;
    logic [RES_W-1:0]      r_slope, n_slope, r_offset, n_offset;

    logic                  r_out_valid, n_out_valid;
    logic                  r_o_inr, n_o_inr, r_o_acc, n_o_acc, r_o_fitv, n_o_fitv;
    logic [6:0]            r_o_bin, n_o_bin;
    logic [7:0]            r_o_cnt, n_o_cnt;
    logic [RES_W-1:0]      r_o_slope, n_o_slope, r_o_offset, n_o_offset;

    logic                  w_mul_start, w_mul_done;
    logic [P_W-1:0]        w_mul_a, w_mul_prod;
    logic [B_W-1:0]        w_mul_b;
    logic                  w_div_start, w_div_done, w_div_ovf;
    logic [P_W-1:0]        w_div_num;
    logic [S_W-1:0]        w_div_steps;
    logic [D_W-1:0]        w_div_den;
    logic [Q_W-1:0]        w_div_quo;

    logic [DEPTH_BITS-1:0] w_lo, w_hi;
    logic [BI_W-1:0]       w_nbm1;
    logic [P_W-1:0]        w_diff;

    dbslf_mul #(.P_W(P_W), .B_W(B_W)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    dbslf_div #(.P_W(P_W), .D_W(D_W), .S_W(S_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_steps (w_div_steps),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo),
        .o_ovf   (w_div_ovf)
    );

    assign o_cfg_ready    = 1'b1;
    assign o_stall        = (r_state != ST_IDLE);
    assign o_valid        = r_out_valid;
    assign o_in_range     = r_o_inr;
    assign o_bin_num      = r_o_bin;
    assign o_accepted     = r_o_acc;
    assign o_sample_count = r_o_cnt;
    assign o_fit_valid    = r_o_fitv;
    assign o_slope        = r_o_slope;
    assign o_offset       = r_o_offset;

    assign w_lo   = DEPTH_BITS'(r_min);
    assign w_hi   = DEPTH_BITS'(r_max);
    assign w_diff = r_prod - w_mul_prod;

    // A bin count of zero acts as one bin; above the store size it clamps.
    always_comb begin
        if (r_bins == 8'd0) begin
            w_nbm1 = '0;
        end else if (32'(r_bins) > MAX_BINS) begin
            w_nbm1 = BI_W'(MAX_BINS - 1);
        end else begin
            w_nbm1 = BI_W'(r_bins - 8'd1);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_wait      = r_wait;
        n_t         = r_t;
        n_m         = r_m;
        n_inr       = r_inr;
        n_acc       = r_acc;
        n_bin       = r_bin;
        n_clr       = r_clr;
        n_n         = r_n;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_sxx       = r_sxx;
        n_sxy       = r_sxy;
        n_prod      = r_prod;
        n_den       = r_den;
        n_num       = r_num;
        n_neg       = r_neg;
        n_fitv      = r_fitv;
        n_slope     = r_slope;
        n_offset    = r_offset;
        n_out_valid = r_out_valid && i_stall;
        n_o_inr     = r_o_inr;
        n_o_acc     = r_o_acc;
        n_o_fitv    = r_o_fitv;
        n_o_bin     = r_o_bin;
        n_o_cnt     = r_o_cnt;
        n_o_slope   = r_o_slope;
        n_o_offset  = r_o_offset;
        w_tk_we     = 1'b0;
        w_tk_addr   = r_bin;
        w_tk_wdata  = 1'b1;
        w_mul_start = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_div_start = 1'b0;
        w_div_num   = '0;
        w_div_steps = '0;
        w_div_den   = '0;

        case (r_state)
            ST_CLEAR: begin
                // One bin flag is cleared per cycle after reset.
                w_tk_we    = 1'b1;
                w_tk_addr  = r_clr;
                w_tk_wdata = 1'b0;
                n_clr      = r_clr + BI_W'(1);
                if (r_clr == BI_W'(MAX_BINS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_t     = DEPTH_BITS'({{DEPTH_BITS{1'b0}}, i_target_depth});
                    n_m     = DEPTH_BITS'({{DEPTH_BITS{1'b0}}, i_measured_depth});
                    n_state = ST_RANGE;
                end
            end
            ST_RANGE: begin
                n_inr = (w_hi > w_lo) && (r_t >= w_lo) && (r_t <= w_hi);
                n_acc = 1'b0;
                n_bin = '0;
                n_wait = 1'b0;
                n_state = n_inr ? ST_BIN_MUL : ST_FIT;
            end
            ST_BIN_MUL: begin
                w_mul_a = P_W'(r_t - w_lo);
                w_mul_b = B_W'(w_nbm1);
                if (!r_wait) begin
                    w_mul_start = 1'b1;
                    n_wait      = 1'b1;
                end else if (w_mul_done) begin
                    n_prod  = w_mul_prod;
                    n_wait  = 1'b0;
                    n_state = ST_BIN_DIV;
                end
            end
            ST_BIN_DIV: begin
                w_div_num   = r_prod << (P_W - BN_W);
                w_div_steps = S_W'(BN_W);
                w_div_den   = D_W'(w_hi - w_lo);
                if (!r_wait) begin
                    w_div_start = 1'b1;
                    n_wait      = 1'b1;
                end else if (w_div_done) begin
                    n_bin   = BI_W'(w_div_quo);
                    n_wait  = 1'b0;
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                // The bin flag is read into r_taken_rd during this cycle.
                n_state = ST_STORE;
            end
            ST_STORE: begin
                if (!r_taken_rd) begin
                    w_tk_we = 1'b1;
                    n_acc   = 1'b1;
                    n_n     = r_n + N_W'(1);
                    n_sx    = r_sx + SX_W'(r_m);
                    n_sy    = r_sy + SX_W'(r_t);
                    n_state = ST_SQ_MUL;
                end else begin
                    n_state = ST_FIT;
                end
            end
            ST_SQ_MUL: begin
                w_mul_a = P_W'(r_m);
                w_mul_b = B_W'(r_m);
                if (!r_wait) begin
                    w_mul_start = 1'b1;
                    n_wait      = 1'b1;
                end else if (w_mul_done) begin
                    n_sxx   = r_sxx + SXX_W'(w_mul_prod);
                    n_wait  = 1'b0;
                    n_state = ST_CROSS_MUL;
                end
            end
            ST_CROSS_MUL: begin
                w_mul_a = P_W'(r_t);
                w_mul_b = B_W'(r_m);
                if (!r_wait) begin
                    w_mul_start = 1'b1;
                    n_wait      = 1'b1;
                end else if (w_mul_done) begin
                    n_sxy   = r_sxy + SXX_W'(w_mul_prod);
                    n_wait  = 1'b0;
                    n_state = ST_FIT;
                end
            end
            ST_FIT: begin
                n_fitv   = 1'b0;
                n_slope  = '0;
                n_offset = '0;
                n_wait   = 1'b0;
                n_state  = (r_n >= N_W'(2)) ? ST_DEN_MUL : ST_OUT;
            end
            ST_DEN_MUL: begin
                w_mul_a = P_W'(r_sxx);
                w_mul_b = B_W'(r_n);
                if (!r_wait) begin
                    w_mul_start = 1'b1;
                    n_wait      = 1'b1;
                end else if (w_mul_done) begin
                    n_prod  = w_mul_prod;
                    n_wait  = 1'b0;
                    n_state = ST_DEN_SQ;
                end
            end
            ST_DEN_SQ: begin
                w_mul_a = P_W'(r_sx);
                w_mul_b = r_sx;
                if (!r_wait) begin
                    w_mul_start = 1'b1;
                    n_wait      = 1'b1;
                end else if (w_mul_done) begin
                    n_den   = D_W'(w_diff);
                    n_wait  = 1'b0;
                    n_state = (D_W'(w_diff) == '0) ? ST_OUT : ST_SN_MUL;
                end
            end
            ST_SN_MUL: begin
                w_mul_a = P_W'(r_sxy);
                w_mul_b = B_W'(r_n);
                if (!r_wait) begin
                    w_mul_start = 1'b1;
                    n_wait      = 1'b1;
                end else if (w_mul_done) begin
                    n_prod  = w_mul_prod;
                    n_wait  = 1'b0;
                    n_state = ST_SN_CROSS;
                end
            end
            ST_SN_CROSS: begin
                w_mul_a = P_W'(r_sy);
                w_mul_b = r_sx;
                if (!r_wait) begin
                    w_mul_start = 1'b1;
                    n_wait      = 1'b1;
                end else if (w_mul_done) begin
                    n_neg   = (w_mul_prod > r_prod);
                    n_num   = n_neg ? (w_mul_prod - r_prod) : w_diff;
                    n_wait  = 1'b0;
                    n_state = ST_SLOPE_DIV;
                end
            end
            ST_SLOPE_DIV: begin
                w_div_num   = r_num << (P_W - D_W);
                w_div_steps = S_W'(SL_STEPS);
                w_div_den   = r_den;
                if (!r_wait) begin
                    w_div_start = 1'b1;
                    n_wait      = 1'b1;
                end else if (w_div_done) begin
                    n_slope = round_sat(w_div_quo, w_div_ovf, r_neg);
                    n_wait  = 1'b0;
                    n_state = ST_ON_MUL;
                end
            end
            ST_ON_MUL: begin
                w_mul_a = P_W'(r_sxx);
                w_mul_b = r_sy;
                if (!r_wait) begin
                    w_mul_start = 1'b1;
                    n_wait      = 1'b1;
                end else if (w_mul_done) begin
                    n_prod  = w_mul_prod;
                    n_wait  = 1'b0;
                    n_state = ST_ON_CROSS;
                end
            end
            ST_ON_CROSS: begin
                w_mul_a = P_W'(r_sxy);
                w_mul_b = r_sx;
                if (!r_wait) begin
                    w_mul_start = 1'b1;
                    n_wait      = 1'b1;
                end else if (w_mul_done) begin
                    n_neg   = (w_mul_prod > r_prod);
                    n_num   = n_neg ? (w_mul_prod - r_prod) : w_diff;
                    n_wait  = 1'b0;
                    n_state = ST_OFFSET_DIV;
                end
            end
            ST_OFFSET_DIV: begin
                w_div_num   = r_num;
                w_div_steps = S_W'(OF_STEPS);
                w_div_den   = r_den;
                if (!r_wait) begin
                    w_div_start = 1'b1;
                    n_wait      = 1'b1;
                end else if (w_div_done) begin
                    n_offset = round_sat(w_div_quo, w_div_ovf, r_neg);
                    n_fitv   = 1'b1;
                    n_wait   = 1'b0;
                    n_state  = ST_OUT;
                end
            end
            ST_OUT: begin
                // Load only when the previous result has been transferred.
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_o_inr     = r_inr;
                    n_o_bin     = r_inr ? 7'(r_bin) : 7'd0;
                    n_o_acc     = r_acc;
                    n_o_cnt     = 8'(r_n);
                    n_o_fitv    = r_fitv;
                    n_o_slope   = r_slope;
                    n_o_offset  = r_offset;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Bin store: one flag per bin, one write and one registered read a cycle.
    always_ff @(posedge i_clk) begin
        if (w_tk_we) begin
            r_taken_mem[w_tk_addr] <= w_tk_wdata;
        end
        r_taken_rd <= r_taken_mem[r_bin];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_wait      <= 1'b0;
            r_min       <= RST_MIN_DEPTH;
            r_max       <= RST_MAX_DEPTH;
            r_bins      <= RST_BIN_COUNT;
            r_clr       <= '0;
            r_n         <= '0;
            r_sx        <= '0;
            r_sy        <= '0;
            r_sxx       <= '0;
            r_sxy       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wait      <= n_wait;
            r_clr       <= n_clr;
            r_n         <= n_n;
            r_sx        <= n_sx;
            r_sy        <= n_sy;
            r_sxx       <= n_sxx;
            r_sxy       <= n_sxy;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MIN_DEPTH: r_min  <= i_cfg_data;
                    CFG_MAX_DEPTH: r_max  <= i_cfg_data;
                    CFG_BIN_COUNT: r_bins <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
        r_t        <= n_t;
        r_m        <= n_m;
        r_inr      <= n_inr;
        r_acc      <= n_acc;
        r_bin      <= n_bin;
        r_prod     <= n_prod;
        r_den      <= n_den;
        r_num      <= n_num;
        r_neg      <= n_neg;
        r_fitv     <= n_fitv;
        r_slope    <= n_slope;
        r_offset   <= n_offset;
        r_o_inr    <= n_o_inr;
        r_o_acc    <= n_o_acc;
        r_o_fitv   <= n_o_fitv;
        r_o_bin    <= n_o_bin;
        r_o_cnt    <= n_o_cnt;
        r_o_slope  <= n_o_slope;
        r_o_offset <= n_o_offset;
    end
endmodule
